/* hw/rtl/fcls_pkg.sv */
package fcls_pkg;

	// default line buffer depth
	localparam int unsigned LINE_MAX_DEF = 256;

	// longest command word in characters
	localparam int unsigned CMD_MAX = 4;

	// byte codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// result status codes
	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_DONE    = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	// one result item
	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  line_length;
		logic [31:0] command_word;
		logic [2:0]  command_length;
		logic        has_parameters;
		logic [8:0]  param_start;
		logic [8:0]  param_length;
		logic        byte_stored;
		logic [7:0]  stored_byte;
		logic [7:0]  stored_index;
	} result_t;

	// ascii lower case to upper case
	function automatic logic [7:0] upcase(input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			r = ch - 8'h20;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/fcls_in_reg.sv */
module fcls_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import fcls_pkg::*;

	// stage is free when empty or its item moves on this cycle
	assign in_ready = !valid_s1 || adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* hw/rtl/fcls_line_tracker.sv */
module fcls_line_tracker #(
	parameter int unsigned LINE_MAX = fcls_pkg::LINE_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_s1,
	output fcls_pkg::result_t res
);
	import fcls_pkg::*;

	localparam int unsigned PW = $clog2(LINE_MAX + 1);
	localparam int unsigned EW = (PW > 9) ? PW : 9;

	logic [PW-1:0] line_q, line_d;
	logic          zero_q, zero_d;
	logic [PW-1:0] zpos_q, zpos_d;
	logic          space_q, space_d;
	logic [PW-1:0] spos_q, spos_d;
	logic          pfound_q, pfound_d;
	logic [PW-1:0] ppos_q, ppos_d;
	logic [31:0]   cmd_q, cmd_d;

	logic [7:0]    ch;
	logic [PW-1:0] line_end;
	logic [PW-1:0] clen;
	logic [PW-1:0] pstart;
	logic [PW-1:0] plen;
	logic [31:0]   word;
	logic [EW-1:0] line_ext, pos_ext, ps_ext, pl_ext, clen_ext;

	// split decode for one byte
	always_comb begin
		res      = '0;
		line_d   = line_q;
		zero_d   = zero_q;
		zpos_d   = zpos_q;
		space_d  = space_q;
		spos_d   = spos_q;
		pfound_d = pfound_q;
		ppos_d   = ppos_q;
		cmd_d    = cmd_q;

		ch       = (byte_s1 == CH_BSLASH) ? CH_SLASH : byte_s1;
		line_end = zero_q ? zpos_q : line_q;
		clen     = space_q ? spos_q : line_end;
		pstart   = pfound_q ? ppos_q : line_end;
		plen     = line_end - pstart;
		line_ext = EW'(line_q);
		pos_ext  = EW'(line_q);
		ps_ext   = EW'(pstart);
		pl_ext   = EW'(plen);
		clen_ext = EW'(clen);

		// upper-cased command characters below the command length
		word = '0;
		for (int k = 0; k < CMD_MAX; k++) begin
			if (clen > PW'(k)) begin
				word[8*k +: 8] = upcase(cmd_q[8*k +: 8]);
			end
		end

		if (ch == CH_CR) begin
			res.status = ST_PENDING;
		end else if (ch != CH_LF) begin
			if (line_q < PW'(LINE_MAX)) begin
				// store the byte
				if (line_q < PW'(CMD_MAX)) begin
					cmd_d[8*line_q[1:0] +: 8] = cmd_q[8*line_q[1:0] +: 8] | ch;
				end
				if (!zero_q) begin
					if (space_q && !pfound_q && ch != CH_SPACE) begin
						pfound_d = 1'b1;
						ppos_d   = line_q;
					end
					if (ch == CH_NUL) begin
						zero_d = 1'b1;
						zpos_d = line_q;
					end else if (ch == CH_SPACE && !space_q) begin
						space_d = 1'b1;
						spos_d  = line_q;
					end
				end
				line_d           = line_q + 1'b1;
				res.byte_stored  = 1'b1;
				res.stored_byte  = ch;
				res.stored_index = pos_ext[7:0];
			end else begin
				// line full
				res.status = ST_ERROR;
				line_d = '0; zero_d = 1'b0; zpos_d = '0; space_d = 1'b0;
				spos_d = '0; pfound_d = 1'b0; ppos_d = '0; cmd_d = '0;
			end
		end else if (line_q == '0) begin
			res.status = ST_EMPTY;
		end else begin
			// line feed closes the line
			if (clen > PW'(CMD_MAX)) begin
				res.status = ST_ERROR;
			end else begin
				res.status         = ST_DONE;
				res.line_length    = line_ext[8:0];
				res.command_word   = word;
				res.command_length = clen_ext[2:0];
				if (space_q) begin
					res.has_parameters = 1'b1;
					res.param_start    = ps_ext[8:0];
					res.param_length   = pl_ext[8:0];
				end
			end
			line_d = '0; zero_d = 1'b0; zpos_d = '0; space_d = 1'b0;
			spos_d = '0; pfound_d = 1'b0; ppos_d = '0; cmd_d = '0;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			zero_q   <= 1'b0;
			zpos_q   <= '0;
			space_q  <= 1'b0;
			spos_q   <= '0;
			pfound_q <= 1'b0;
			ppos_q   <= '0;
			cmd_q    <= '0;
		end else if (step) begin
			line_q   <= line_d;
			zero_q   <= zero_d;
			zpos_q   <= zpos_d;
			space_q  <= space_d;
			spos_q   <= spos_d;
			pfound_q <= pfound_d;
			ppos_q   <= ppos_d;
			cmd_q    <= cmd_d;
		end
	end

	// a stored byte advances the line by one
	a_store_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.byte_stored |=> line_q == $past(line_q) + 1'b1)
		else $error("line index did not advance on stored item");

	// a finished or failed line restarts
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.status == ST_DONE || res.status == ST_ERROR)
		|=> line_q == '0 && !space_q && !zero_q && cmd_q == '0)
		else $error("line state not cleared after line end");

	// a completed line never carries an over-long command
	a_cmd_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.status == ST_DONE |-> res.command_length <= 3'(CMD_MAX))
		else $error("command length above limit");

	// the space lies inside the line and the parameter starts after it
	a_param_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		space_q |-> spos_q < line_q && (!pfound_q || ppos_q > spos_q))
		else $error("parameter position out of order");

endmodule

/* hw/rtl/fcls_out_reg.sv */
module fcls_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fcls_pkg::result_t res_in,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output fcls_pkg::result_t res_q
);
	import fcls_pkg::*;

	// room for a new result when empty or the current one leaves
	assign free = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

/* hw/rtl/ftp_command_line_splitter_unit.sv */
// path: each item is held in the input register; its result is held in the result register
// throughput: one item per cycle while out_ready holds; line state updates once per item
// stalls: with both registers holding an item, in_ready follows out_ready in the same cycle
// reset (arst_n low, asynchronous) empties both registers and clears the line state
module ftp_command_line_splitter_unit #(
	parameter int unsigned LINE_MAX = fcls_pkg::LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [8:0]  line_length,
	output logic [31:0] command_word,
	output logic [2:0]  command_length,
	output logic        has_parameters,
	output logic [8:0]  param_start,
	output logic [8:0]  param_length,
	output logic        byte_stored,
	output logic [7:0]  stored_byte,
	output logic [7:0]  stored_index
);
	import fcls_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       free;
	result_t    res_comb;
	result_t    res_q;

	// item moves from the input register into the result register
	assign adv = valid_s1 && free;

	fcls_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	fcls_line_tracker #(
		.LINE_MAX (LINE_MAX)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_s1 (byte_s1),
		.res     (res_comb)
	);

	fcls_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res_in    (res_comb),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// result fields
	assign status         = res_q.status;
	assign line_length    = res_q.line_length;
	assign command_word   = res_q.command_word;
	assign command_length = res_q.command_length;
	assign has_parameters = res_q.has_parameters;
	assign param_start    = res_q.param_start;
	assign param_length   = res_q.param_length;
	assign byte_stored    = res_q.byte_stored;
	assign stored_byte    = res_q.stored_byte;
	assign stored_index   = res_q.stored_index;

endmodule
